[rtl/pbcrs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcrs_pkg
// shared types, register map, combo masks and phase codes for the pad bus
// combo reset sequencer
// ----------------------------------------------------------------------------
package pbcrs_pkg;

    // default frame length in bytes
    localparam int FRAME_BYTES_DEF = 6;

    // apb register map
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam logic [2:0] REG_HOLDOFF  = 3'd0;
    localparam logic [2:0] REG_DEBOUNCE = 3'd1;
    localparam logic [2:0] REG_SHORT    = 3'd2;
    localparam logic [2:0] REG_LONG     = 3'd3;
    localparam logic [2:0] REG_POST     = 3'd4;

    // register reset values
    localparam logic [31:0] HOLDOFF_RST  = 32'd2000000;
    localparam logic [31:0] DEBOUNCE_RST = 32'd600000;
    localparam logic [31:0] SHORT_RST    = 32'd400000;
    localparam logic [31:0] LONG_RST     = 32'd8000000;
    localparam logic [31:0] POST_RST     = 32'd8000000;

    // kept byte positions within a frame
    localparam int BYTE_TWO_IDX   = 2;
    localparam int BYTE_THREE_IDX = 3;
    localparam int BYTE_FOUR_IDX  = 4;

    // active-low button masks
    localparam logic [7:0] MASK_B2_SEL   = 8'h40;
    localparam logic [7:0] MASK_B3_START = 8'h08;
    localparam logic [7:0] MASK_B4_HI    = 8'h80;
    localparam logic [7:0] MASK_B4_MID   = 8'h08;
    localparam logic [7:0] MASK_B4_LO    = 8'h04;

    // combo / pending action codes
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_SHORT = 2'd1;
    localparam logic [1:0] ACT_LONG  = 2'd2;

    // reported phase codes
    localparam logic [2:0] PH_CODE_LISTEN  = 3'd0;
    localparam logic [2:0] PH_CODE_HOLDOFF = 3'd1;
    localparam logic [2:0] PH_CODE_CONFIRM = 3'd2;
    localparam logic [2:0] PH_CODE_PULSE   = 3'd3;
    localparam logic [2:0] PH_CODE_POST    = 3'd4;

    typedef struct packed {
        logic [31:0] holdoff_ticks;
        logic [31:0] debounce_ticks;
        logic [31:0] short_pulse_ticks;
        logic [31:0] long_pulse_ticks;
        logic [31:0] post_reset_ticks;
    } pbcrs_cfg_t;

    // one classified sample between front and back
    typedef struct packed {
        logic       done;
        logic [1:0] combo;
    } pbcrs_evt_t;

    function automatic logic [1:0] combo_of(input logic [7:0] b2, input logic [7:0] b3,
                                            input logic [7:0] b4);
        logic common;
        common = ((b2 & MASK_B2_SEL) == 8'h00) && ((b4 & MASK_B4_HI) == 8'h00)
                 && ((b4 & MASK_B4_MID) == 8'h00);
        if (common && ((b3 & MASK_B3_START) == 8'h00)) begin
            return ACT_SHORT;
        end else if (common && ((b4 & MASK_B4_LO) == 8'h00)) begin
            return ACT_LONG;
        end
        return ACT_NONE;
    endfunction

    function automatic logic [31:0] at_least_one(input logic [31:0] v);
        return (v == 32'd0) ? 32'd1 : v;
    endfunction

endpackage

[rtl/pbcrs_frame_rx.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcrs_frame_rx
// front end: tracks select and clock edges, shifts in frame bits and
// classifies each sample as frame done plus combo of the kept bytes
// ----------------------------------------------------------------------------
module pbcrs_frame_rx #(
    parameter int FRAME_BYTES = pbcrs_pkg::FRAME_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  smp_take,
    input  logic                  select_level,
    input  logic                  clock_level,
    input  logic                  data_level,
    output pbcrs_pkg::pbcrs_evt_t evt
);
    import pbcrs_pkg::*;

    localparam int TotalBits = FRAME_BYTES * 8;
    localparam int CntW      = $clog2(TotalBits + 1);
    localparam int IdxW      = CntW - 3;

    logic            clock_prev_reg, clock_prev_next;
    logic            select_prev_reg, select_prev_next;
    logic            in_frame_reg, in_frame_next;
    logic [CntW-1:0] bit_count_reg, bit_count_next;
    logic [7:0]      shift_reg, shift_next;
    logic [7:0]      b2_reg, b2_next, b3_reg, b3_next, b4_reg, b4_next;
    logic [7:0]      st2_reg, st2_next, st3_reg, st3_next, st4_reg, st4_next;
    logic            sel_rise, sel_fall, done, take_bit;
    logic [7:0]      shift_bit;
    logic [IdxW-1:0] byte_idx;

    assign sel_rise = select_level & ~select_prev_reg;
    assign sel_fall = ~select_level & select_prev_reg;
    assign done     = sel_rise & in_frame_reg & (bit_count_reg == CntW'(TotalBits));

    always_comb begin
        in_frame_next  = in_frame_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        b2_next        = b2_reg;
        b3_next        = b3_reg;
        b4_next        = b4_reg;
        st2_next       = st2_reg;
        st3_next       = st3_reg;
        st4_next       = st4_reg;
        if (sel_rise) begin
            if (done) begin
                b2_next = st2_reg;
                b3_next = st3_reg;
                b4_next = st4_reg;
            end
            in_frame_next = 1'b0;
        end else if (sel_fall) begin
            in_frame_next  = 1'b1;
            bit_count_next = '0;
            shift_next     = '0;
        end
        take_bit  = in_frame_next & ~select_level & clock_level & ~clock_prev_reg
                    & (bit_count_next < CntW'(TotalBits));
        shift_bit = shift_next | ({7'd0, data_level} << bit_count_next[2:0]);
        byte_idx  = bit_count_next[CntW-1:3];
        if (take_bit) begin
            if (bit_count_next[2:0] == 3'd7) begin
                if (byte_idx == IdxW'(BYTE_TWO_IDX)) begin
                    st2_next = shift_bit;
                end else if (byte_idx == IdxW'(BYTE_THREE_IDX)) begin
                    st3_next = shift_bit;
                end else if (byte_idx == IdxW'(BYTE_FOUR_IDX)) begin
                    st4_next = shift_bit;
                end
                shift_next = '0;
            end else begin
                shift_next = shift_bit;
            end
            bit_count_next = bit_count_next + CntW'(1);
        end
        clock_prev_next  = clock_level;
        select_prev_next = select_level;
    end

    // classification of this sample, taken by the queue on smp_take
    assign evt.done  = done;
    assign evt.combo = combo_of(b2_next, b3_next, b4_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_prev_reg  <= 1'b1;
            select_prev_reg <= 1'b1;
            in_frame_reg    <= 1'b0;
            bit_count_reg   <= '0;
            shift_reg       <= '0;
            b2_reg          <= 8'hFF;
            b3_reg          <= 8'hFF;
            b4_reg          <= 8'hFF;
            st2_reg         <= 8'hFF;
            st3_reg         <= 8'hFF;
            st4_reg         <= 8'hFF;
        end else if (smp_take) begin
            clock_prev_reg  <= clock_prev_next;
            select_prev_reg <= select_prev_next;
            in_frame_reg    <= in_frame_next;
            bit_count_reg   <= bit_count_next;
            shift_reg       <= shift_next;
            b2_reg          <= b2_next;
            b3_reg          <= b3_next;
            b4_reg          <= b4_next;
            st2_reg         <= st2_next;
            st3_reg         <= st3_next;
            st4_reg         <= st4_next;
        end
    end

endmodule

[rtl/pbcrs_evt_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcrs_evt_queue
// two-entry queue of classified samples between front and back
// ----------------------------------------------------------------------------
module pbcrs_evt_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  pbcrs_pkg::pbcrs_evt_t push_evt,
    input  logic                  pop,
    output pbcrs_pkg::pbcrs_evt_t head_evt,
    output logic                  not_empty,
    output logic                  not_full
);
    import pbcrs_pkg::*;

    logic [1:0] count_reg, count_next;
    pbcrs_evt_t slot0_reg, slot1_reg;

    assign head_evt  = slot0_reg;
    assign not_empty = (count_reg != 2'd0);
    assign not_full  = (count_reg != 2'd2);

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // head always sits in slot0
    always_ff @(posedge aclk) begin
        if (push && pop) begin
            if (count_reg == 2'd1) begin
                slot0_reg <= push_evt;
            end else begin
                slot0_reg <= slot1_reg;
                slot1_reg <= push_evt;
            end
        end else if (push) begin
            if (count_reg == 2'd0) begin
                slot0_reg <= push_evt;
            end else begin
                slot1_reg <= push_evt;
            end
        end else if (pop) begin
            slot0_reg <= slot1_reg;
        end
    end

endmodule

[rtl/pbcrs_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcrs_sequencer
// back end: holdoff / confirm / pulse / post phase sequencing with its tick
// timer, and the result register
// ----------------------------------------------------------------------------
module pbcrs_sequencer (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pbcrs_pkg::pbcrs_cfg_t cfg,
    input  logic                  evt_avail,
    input  pbcrs_pkg::pbcrs_evt_t evt,
    output logic                  evt_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_reset_level,
    output logic [2:0]            m_phase_code,
    output logic                  m_frame_done,
    output logic [1:0]            m_combo_code
);
    import pbcrs_pkg::*;

    typedef enum logic [4:0] {
        PH_LISTEN  = 5'b00001,
        PH_HOLDOFF = 5'b00010,
        PH_CONFIRM = 5'b00100,
        PH_PULSE   = 5'b01000,
        PH_POST    = 5'b10000
    } phase_t;

    typedef enum logic [3:0] {
        HS_PLAIN     = 4'b0001,
        HS_DETECTED  = 4'b0010,
        HS_DEBOUNCE  = 4'b0100,
        HS_CONFIRMED = 4'b1000
    } hold_t;

    phase_t      phase_reg, phase_next;
    hold_t       hold_reg, hold_next;
    logic [1:0]  pend_reg, pend_next;
    logic [31:0] timer_reg, timer_next, timer_dec;
    logic        valid_reg;
    logic [2:0]  code_next;

    assign evt_pop   = evt_avail & (~valid_reg | m_ready);
    assign timer_dec = timer_reg - 32'(timer_reg != 32'd0);

    always_comb begin
        phase_next = phase_reg;
        hold_next  = hold_reg;
        pend_next  = pend_reg;
        timer_next = timer_reg;
        unique case (phase_reg)
            PH_LISTEN: begin
                if (evt.done) begin
                    phase_next = PH_HOLDOFF;
                    timer_next = at_least_one(cfg.holdoff_ticks);
                    if (evt.combo != ACT_NONE) begin
                        pend_next = evt.combo;
                        hold_next = HS_DETECTED;
                    end else begin
                        hold_next = HS_PLAIN;
                    end
                end
            end
            PH_CONFIRM: begin
                if (evt.done) begin
                    phase_next = PH_HOLDOFF;
                    timer_next = at_least_one(cfg.holdoff_ticks);
                    if (evt.combo == pend_reg && evt.combo != ACT_NONE) begin
                        hold_next = HS_CONFIRMED;
                    end else begin
                        pend_next = ACT_NONE;
                        hold_next = HS_PLAIN;
                    end
                end
            end
            PH_HOLDOFF: begin
                timer_next = timer_dec;
                if (timer_dec == 32'd0) begin
                    priority if (hold_reg == HS_DETECTED && cfg.debounce_ticks != 32'd0) begin
                        hold_next  = HS_DEBOUNCE;
                        timer_next = cfg.debounce_ticks;
                    end else if (hold_reg == HS_DETECTED || hold_reg == HS_DEBOUNCE) begin
                        phase_next = PH_CONFIRM;
                        timer_next = '0;
                    end else if (hold_reg == HS_CONFIRMED) begin
                        phase_next = PH_PULSE;
                        timer_next = at_least_one((pend_reg == ACT_LONG) ?
                                                  cfg.long_pulse_ticks :
                                                  cfg.short_pulse_ticks);
                    end else begin
                        phase_next = PH_LISTEN;
                        pend_next  = ACT_NONE;
                        timer_next = '0;
                    end
                end
            end
            PH_PULSE: begin
                timer_next = timer_dec;
                if (timer_dec == 32'd0) begin
                    pend_next = ACT_NONE;
                    if (cfg.post_reset_ticks == 32'd0) begin
                        phase_next = PH_LISTEN;
                        timer_next = '0;
                    end else begin
                        phase_next = PH_POST;
                        timer_next = cfg.post_reset_ticks;
                    end
                end
            end
            PH_POST: begin
                timer_next = timer_dec;
                if (timer_dec == 32'd0) begin
                    phase_next = PH_LISTEN;
                end
            end
            default: begin
                phase_next = PH_LISTEN;
                timer_next = '0;
            end
        endcase
    end

    always_comb begin
        unique case (phase_next)
            PH_LISTEN:  code_next = PH_CODE_LISTEN;
            PH_HOLDOFF: code_next = PH_CODE_HOLDOFF;
            PH_CONFIRM: code_next = PH_CODE_CONFIRM;
            PH_PULSE:   code_next = PH_CODE_PULSE;
            PH_POST:    code_next = PH_CODE_POST;
            default:    code_next = PH_CODE_LISTEN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LISTEN;
            hold_reg  <= HS_PLAIN;
            pend_reg  <= ACT_NONE;
            timer_reg <= '0;
            valid_reg <= 1'b0;
        end else if (evt_pop) begin
            phase_reg <= phase_next;
            hold_reg  <= hold_next;
            pend_reg  <= pend_next;
            timer_reg <= timer_next;
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (evt_pop) begin
            m_reset_level <= (phase_next != PH_PULSE);
            m_phase_code  <= code_next;
            m_frame_done  <= evt.done;
            m_combo_code  <= evt.combo;
        end
    end

    assign m_valid = valid_reg;

endmodule

[rtl/pad_bus_combo_reset_sequencer.sv]
`timescale 1ns / 1ps
// path: a sample accepted on s_ passes through the queue slot and then the result register to m_
// throughput: one sample per cycle sustained while m_ready holds high; the front end, two-entry queue and
//   sequencer each do one sample per cycle unless stalled, the result register parts the sides
// reset: aresetn synchronous active low; clears edge trackers, frame state,
//   phase (listen), timer and queue; registers return to their default tick counts
// ----------------------------------------------------------------------------
// pad_bus_combo_reset_sequencer
// watches a sampled game pad bus, detects reset button combos, confirms them
// after a debounce wait and drives a short or long reset pulse
// ----------------------------------------------------------------------------
module pad_bus_combo_reset_sequencer #(
    parameter int FRAME_BYTES = pbcrs_pkg::FRAME_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // sample request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_select_level,
    input  logic                          s_clock_level,
    input  logic                          s_data_level,
    // result request channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_reset_level,
    output logic [2:0]                    m_phase_code,
    output logic                          m_frame_done,
    output logic [1:0]                    m_combo_code,
    // apb configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pbcrs_pkg::APB_AW-1:0]  paddr,
    input  logic [pbcrs_pkg::APB_DW-1:0]  pwdata,
    output logic [pbcrs_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);
    import pbcrs_pkg::*;

    pbcrs_cfg_t cfg_reg;
    pbcrs_evt_t front_evt, head_evt;
    logic       smp_take, q_not_empty, q_not_full, q_pop, cfg_wr;
    logic [2:0] reg_idx;

    // ------------------------------------------------------------------
    // configuration registers, one word each at byte offset 4*index
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.holdoff_ticks     <= HOLDOFF_RST;
            cfg_reg.debounce_ticks    <= DEBOUNCE_RST;
            cfg_reg.short_pulse_ticks <= SHORT_RST;
            cfg_reg.long_pulse_ticks  <= LONG_RST;
            cfg_reg.post_reset_ticks  <= POST_RST;
        end else if (cfg_wr) begin
            // writes beyond the map are dropped
            unique case (reg_idx)
                REG_HOLDOFF:  cfg_reg.holdoff_ticks     <= pwdata;
                REG_DEBOUNCE: cfg_reg.debounce_ticks    <= pwdata;
                REG_SHORT:    cfg_reg.short_pulse_ticks <= pwdata;
                REG_LONG:     cfg_reg.long_pulse_ticks  <= pwdata;
                REG_POST:     cfg_reg.post_reset_ticks  <= pwdata;
                default:      ;
            endcase
        end
    end

    // read back, unmapped words read as zero
    always_comb begin
        unique case (reg_idx)
            REG_HOLDOFF:  prdata = cfg_reg.holdoff_ticks;
            REG_DEBOUNCE: prdata = cfg_reg.debounce_ticks;
            REG_SHORT:    prdata = cfg_reg.short_pulse_ticks;
            REG_LONG:     prdata = cfg_reg.long_pulse_ticks;
            REG_POST:     prdata = cfg_reg.post_reset_ticks;
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // front end: takes a sample whenever the queue has room
    // ------------------------------------------------------------------
    assign s_ready  = q_not_full;
    assign smp_take = s_valid & s_ready;

    pbcrs_frame_rx #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_frame_rx (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .smp_take     (smp_take),
        .select_level (s_select_level),
        .clock_level  (s_clock_level),
        .data_level   (s_data_level),
        .evt          (front_evt)
    );

    // decoupling queue, so a stalled result side does not stall sampling at once
    pbcrs_evt_queue u_evt_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (smp_take),
        .push_evt  (front_evt),
        .pop       (q_pop),
        .head_evt  (head_evt),
        .not_empty (q_not_empty),
        .not_full  (q_not_full)
    );

    // ------------------------------------------------------------------
    // back end: phase sequencing and result register
    // ------------------------------------------------------------------
    pbcrs_sequencer u_sequencer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .evt_avail     (q_not_empty),
        .evt           (head_evt),
        .evt_pop       (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_reset_level (m_reset_level),
        .m_phase_code  (m_phase_code),
        .m_frame_done  (m_frame_done),
        .m_combo_code  (m_combo_code)
    );

endmodule

[rtl/pbcrs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcrs_port_checks
// port-level checks on the result channel of the sequencer
// ----------------------------------------------------------------------------
module pbcrs_port_checks (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_reset_level,
    input logic [2:0] m_phase_code,
    input logic       m_frame_done,
    input logic [1:0] m_combo_code
);
    import pbcrs_pkg::*;

    logic       out_take;
    logic       seen_reg;
    logic [1:0] last_combo_reg;

    assign out_take = m_valid & m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg       <= 1'b0;
            last_combo_reg <= ACT_NONE;
        end else if (out_take) begin
            seen_reg       <= 1'b1;
            last_combo_reg <= m_combo_code;
        end
    end

    // reset output is low exactly in the pulse phase
    a_reset_matches_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_reset_level == (m_phase_code != PH_CODE_PULSE)))
        else $error("reset level disagrees with phase");

    // kept combo only changes on a completed frame
    a_combo_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_take && seen_reg && !m_frame_done) |-> (m_combo_code == last_combo_reg))
        else $error("combo changed without a completed frame");

    // no result is offered straight after reset
    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_phase_code)
                                   && $stable(m_combo_code) && $stable(m_frame_done)))
        else $error("stalled result changed");

endmodule

bind pad_bus_combo_reset_sequencer pbcrs_port_checks u_pbcrs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_reset_level (m_reset_level),
    .m_phase_code  (m_phase_code),
    .m_frame_done  (m_frame_done),
    .m_combo_code  (m_combo_code)
);
